// ===== sv/dgr_pkg.sv =====
// Shared types, constants and font lookup for the double-size decimal glyph renderer.
// No dependencies; every other file of the block imports this package.
package dgr_pkg;

    localparam int unsigned MAX_DIGITS_DEF = 10;
    localparam int unsigned GLYPH_COLUMNS  = 5;
    localparam int unsigned GLYPH_COUNT    = 17;

    localparam logic [7:0]  GLYPH_ADVANCE  = 8'd12;
    localparam logic [2:0]  LAST_COL       = 3'(GLYPH_COLUMNS - 1);
    localparam logic [31:0] RECIP_10       = 32'hCCCC_CCCD;
    localparam logic        CMD_NUMBER     = 1'b0;
    localparam logic        CMD_GLYPH      = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] value;
        logic [7:0]  start_column;
        logic [1:0]  text_line;
    } dgr_in_t;

    typedef struct packed {
        logic [2:0] top_page;
        logic [7:0] column;
        logic [7:0] top_byte;
        logic [7:0] bottom_byte;
        logic [7:0] next_column;
        logic       last;
    } dgr_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_EMIT
    } dgr_state_t;

    // Font row of one glyph; column 0 sits in the top byte.
    function automatic logic [39:0] font_row(input logic [4:0] id);
        logic [39:0] row;
        case (id)
            5'd0:    row = 40'h3E_51_49_45_3E;
            5'd1:    row = 40'h00_42_7F_40_00;
            5'd2:    row = 40'h42_61_51_49_46;
            5'd3:    row = 40'h21_41_45_4B_31;
            5'd4:    row = 40'h18_14_12_7F_10;
            5'd5:    row = 40'h27_45_45_45_39;
            5'd6:    row = 40'h3C_4A_49_49_30;
            5'd7:    row = 40'h01_71_09_05_03;
            5'd8:    row = 40'h36_49_49_49_36;
            5'd9:    row = 40'h06_49_49_29_1E;
            5'd10:   row = 40'hFC_24_24_24_18;
            5'd11:   row = 40'h7C_08_04_04_78;
            5'd12:   row = 40'h3C_40_40_20_7C;
            5'd13:   row = 40'h7C_04_18_04_78;
            5'd14:   row = 40'h7F_09_09_09_01;
            5'd15:   row = 40'h7F_08_08_08_7F;
            5'd16:   row = 40'h00_60_60_00_00;
            default: row = '0;
        endcase
        return row;
    endfunction

    function automatic logic [7:0] font_col(input logic [4:0] id, input logic [2:0] c);
        logic [39:0] row;
        logic [7:0]  bits;
        row = font_row(id);
        case (c)
            3'd0:    bits = row[39:32];
            3'd1:    bits = row[31:24];
            3'd2:    bits = row[23:16];
            3'd3:    bits = row[15:8];
            3'd4:    bits = row[7:0];
            default: bits = '0;
        endcase
        return bits;
    endfunction

    // Each nibble bit j fills bits 2j and 2j+1.
    function automatic logic [7:0] double_nibble(input logic [3:0] n);
        return {n[3], n[3], n[2], n[2], n[1], n[1], n[0], n[0]};
    endfunction

endpackage

// ===== sv/dgr_div10.sv =====
// Shared divide-by-ten unit: reciprocal multiply, registered product, then quotient and remainder.
// Depends on dgr_pkg.
module dgr_div10 (
    input  logic        clk,
    input  logic        mul_en,
    input  logic [31:0] dividend,
    output logic [31:0] quotient,
    output logic [3:0]  remainder
);
    import dgr_pkg::*;

    logic [63:0] prod_reg;
    logic [31:0] times_ten;

    // capture the product; dividend must hold until the next cycle
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= {32'd0, dividend} * {32'd0, RECIP_10};
        end
    end

    assign quotient  = {3'd0, prod_reg[63:35]};
    assign times_ten = {quotient[28:0], 3'd0} + {quotient[30:0], 1'b0};
    assign remainder = 4'(dividend - times_ten);

endmodule

// ===== sv/decimal_glyph_renderer_2x_top.sv =====
// Top level of the double-size decimal glyph renderer: sequencer, digit stack,
// output register. Depends on dgr_pkg and dgr_div10.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one request, either a number to print
//   in decimal (cmd = CMD_NUMBER) or a glyph id 0..16 (cmd = CMD_GLYPH).
//   out channel (out_valid/out_ready/out_data): one result per font column, five
//   per glyph, with last set on the final column of the request.
// Timing:
//   A number goes through the shared divide-by-ten unit once per decimal digit
//   (multiply, then correct and push), and its results follow once every digit
//   is stacked. Results then leave at one per cycle while out_ready is high,
//   5*D in all for a number of D digits.
//   A glyph request skips the divide phase and gives five results.
//   The block takes one request at a time; in_ready is high only when idle.
//   A glyph id above 16 is dropped with no results, and the block stays ready.
// Reset: rst_n clears the sequencer state and the output valid; payload is left as is.
// Stall: when out_ready is low the output register holds its result and the
//   sequencer waits; nothing is lost. The last result may still sit in the
//   output register while the next request is accepted.
module decimal_glyph_renderer_2x_top #(
    parameter int unsigned MAX_DIGITS = dgr_pkg::MAX_DIGITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dgr_pkg::dgr_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output dgr_pkg::dgr_out_t out_data
);
    import dgr_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    dgr_state_t       state_reg, state_next;
    logic [31:0]      val_reg, val_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [7:0]       col_reg, col_next;
    logic [1:0]       line_reg, line_next;
    logic             gcmd_reg, gcmd_next;
    logic [4:0]       gid_reg, gid_next;
    logic [2:0]       cidx_reg, cidx_next;
    logic             out_valid_reg, out_valid_next;
    dgr_out_t         out_data_reg, out_data_next;

    logic [3:0]       digits_reg [MAX_DIGITS];
    logic             push;

    logic             mul_en;
    logic [31:0]      quotient;
    logic [3:0]       remainder;
    logic [4:0]       glyph_id;
    logic [7:0]       font_bits;
    logic             out_load;

    dgr_div10 u_div10 (
        .clk       (clk),
        .mul_en    (mul_en),
        .dividend  (val_reg),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // glyph under emission: the request's id, or the stacked digit
    assign glyph_id  = (gcmd_reg == CMD_GLYPH) ? gid_reg : {1'b0, digits_reg[ptr_reg]};
    assign font_bits = font_col(glyph_id, cidx_reg);

    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        col_next       = col_reg;
        line_next      = line_reg;
        gcmd_next      = gcmd_reg;
        gid_next       = gid_reg;
        cidx_next      = cidx_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        mul_en         = 1'b0;
        push           = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    val_next  = in_data.value;
                    col_next  = in_data.start_column;
                    line_next = in_data.text_line;
                    gcmd_next = in_data.cmd;
                    gid_next  = in_data.value[4:0];
                    cnt_next  = '0;
                    ptr_next  = '0;
                    cidx_next = '0;
                    if (in_data.cmd == CMD_NUMBER)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (in_data.value < 32'(GLYPH_COUNT))
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_MUL:
            begin
                mul_en     = 1'b1;
                state_next = ST_FIX;
            end

            ST_FIX:
            begin
                // push the low digit, keep dividing until nothing is left or the stack is full
                push     = 1'b1;
                val_next = quotient;
                cnt_next = cnt_reg + CNT_W'(1);
                if (quotient == 32'd0 || cnt_next == CNT_W'(MAX_DIGITS))
                begin
                    ptr_next   = cnt_reg[IDX_W-1:0];
                    cidx_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end

            ST_EMIT:
            begin
                out_load = !out_valid_reg || out_ready;
                if (out_load)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.top_page    = {line_reg, 1'b0};
                    out_data_next.column      = col_reg + {4'd0, cidx_reg, 1'b0};
                    out_data_next.top_byte    = double_nibble(font_bits[3:0]);
                    out_data_next.bottom_byte = double_nibble(font_bits[7:4]);
                    out_data_next.next_column = col_reg + GLYPH_ADVANCE;
                    out_data_next.last        = (ptr_reg == '0) && (cidx_reg == LAST_COL);
                    if (cidx_reg == LAST_COL)
                    begin
                        cidx_next = '0;
                        col_next  = col_reg + GLYPH_ADVANCE;
                        if (ptr_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            ptr_next = ptr_reg - IDX_W'(1);
                        end
                    end
                    else
                    begin
                        cidx_next = cidx_reg + 3'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        cnt_reg      <= cnt_next;
        ptr_reg      <= ptr_next;
        col_reg      <= col_next;
        line_reg     <= line_next;
        gcmd_reg     <= gcmd_next;
        gid_reg      <= gid_next;
        cidx_reg     <= cidx_next;
        out_data_reg <= out_data_next;
    end

    // digit stack, least significant digit at the bottom
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            digits_reg[cnt_reg[IDX_W-1:0]] <= remainder;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/dgr_checker.sv =====
// Port-level checker for the double-size decimal glyph renderer, bound to its top.
// Depends on dgr_pkg and decimal_glyph_renderer_2x_top.
module dgr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input dgr_pkg::dgr_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input dgr_pkg::dgr_out_t out_data
);
    import dgr_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // a number request always occupies the block
    a_busy_number: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.cmd == CMD_NUMBER |=> !in_ready)
        else $error("ready right after a number request");

    // a non-final result on the port means more columns are still owed
    a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> !in_ready)
        else $error("ready before the final result");

    // the band always starts on an even page
    a_even_page: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.top_page[0] == 1'b0)
        else $error("odd top page");

endmodule

bind decimal_glyph_renderer_2x_top dgr_checker u_dgr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
